[src/mtq_pkg.sv]
package mtq_pkg;

    // Sensor table
    localparam int MAX_SENSORS = 32;
    localparam int SID_W       = 5;
    localparam int MEM_DEPTH   = (MAX_SENSORS < (1 << SID_W)) ? MAX_SENSORS : (1 << SID_W);
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Datapath widths
    localparam int POS_W    = 32;
    localparam int DIFF_W   = POS_W + 1;
    localparam int DSUM_W   = POS_W + 3;
    localparam int CNT_W    = 8;
    localparam int THR_W    = 20;
    localparam int GAIN_W   = 9;
    localparam int FRAC_W   = GAIN_W - 1;
    localparam int ACC_W    = DIFF_W + GAIN_W + 1;

    // Stream packing
    localparam int IN_BITS  = SID_W + 3 * POS_W;
    localparam int TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - IN_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    localparam logic [CNT_W-1:0]  RST_ACTIVATION  = CNT_W'(5);
    localparam logic [CNT_W-1:0]  RST_DISAPPEARED = CNT_W'(5);
    localparam logic [CNT_W-1:0]  RST_HOLDS_STILL = CNT_W'(5);
    localparam logic [CNT_W-1:0]  RST_NOISE       = CNT_W'(2);
    localparam logic [THR_W-1:0]  RST_HOLD_DIST   = THR_W'(1024);
    localparam logic [THR_W-1:0]  RST_NOISE_DIST  = THR_W'(102400);
    localparam logic [GAIN_W-1:0] RST_GAIN        = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] RST_STILL_GAIN  = GAIN_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVATION  = 3'd0,
        CFG_DISAPPEARED = 3'd1,
        CFG_HOLDS_STILL = 3'd2,
        CFG_NOISE       = 3'd3,
        CFG_HOLD_DIST   = 3'd4,
        CFG_NOISE_DIST  = 3'd5,
        CFG_GAIN        = 3'd6,
        CFG_STILL_GAIN  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0]  activation_amount;
        logic [CNT_W-1:0]  disappeared_amount;
        logic [CNT_W-1:0]  holds_still_amount;
        logic [CNT_W-1:0]  noise_amount;
        logic [THR_W-1:0]  hold_distance;
        logic [THR_W-1:0]  noise_distance;
        logic [GAIN_W-1:0] filter_gain;
        logic [GAIN_W-1:0] still_filter_gain;
    } cfg_t;

    // Per-sensor flags and counters, one word of the control RAM
    typedef struct packed {
        logic             has_last;
        logic             active;
        logic             still;
        logic [CNT_W-1:0] act_cnt;
        logic [CNT_W-1:0] gone_cnt;
        logic [CNT_W-1:0] still_cnt;
        logic [CNT_W-1:0] noise_cnt;
    } ctrl_t;

    // x sits in the lowest bits
    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } pos_t;

    typedef struct packed {
        ctrl_t             nxt;
        logic              pos_we;
        logic              emit;
        logic              use_filter;
        logic [GAIN_W-1:0] gain;
    } upd_t;

endpackage

[src/mtq_ram.sv]
module mtq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/mtq_cfg.sv]
module mtq_cfg
    import mtq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ACTIVATION:  cfg_next.activation_amount  = cfg_data[CNT_W-1:0];
                CFG_DISAPPEARED: cfg_next.disappeared_amount = cfg_data[CNT_W-1:0];
                CFG_HOLDS_STILL: cfg_next.holds_still_amount = cfg_data[CNT_W-1:0];
                CFG_NOISE:       cfg_next.noise_amount       = cfg_data[CNT_W-1:0];
                CFG_HOLD_DIST:   cfg_next.hold_distance      = cfg_data[THR_W-1:0];
                CFG_NOISE_DIST:  cfg_next.noise_distance     = cfg_data[THR_W-1:0];
                CFG_GAIN:        cfg_next.filter_gain        = cfg_data[GAIN_W-1:0];
                CFG_STILL_GAIN:  cfg_next.still_filter_gain  = cfg_data[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.activation_amount  <= RST_ACTIVATION;
            cfg_reg.disappeared_amount <= RST_DISAPPEARED;
            cfg_reg.holds_still_amount <= RST_HOLDS_STILL;
            cfg_reg.noise_amount       <= RST_NOISE;
            cfg_reg.hold_distance      <= RST_HOLD_DIST;
            cfg_reg.noise_distance     <= RST_NOISE_DIST;
            cfg_reg.filter_gain        <= RST_GAIN;
            cfg_reg.still_filter_gain  <= RST_STILL_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/mtq_update.sv]
module mtq_update
    import mtq_pkg::*;
(
    input  ctrl_t                    cur,
    input  logic signed [DSUM_W-1:0] dsum,
    input  cfg_t                     cfg,
    output upd_t                     upd
);

    logic [DSUM_W-1:0] jump;
    logic              moved;
    logic              small_move;
    logic              big_move;
    logic [GAIN_W-1:0] gain_sel;
    ctrl_t             n;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
    endfunction

    assign jump       = dsum[DSUM_W-1] ? unsigned'(-dsum) : unsigned'(dsum);
    assign moved      = (dsum != '0);
    assign small_move = moved && (jump < DSUM_W'(cfg.hold_distance));
    assign big_move   = jump > DSUM_W'(cfg.noise_distance);

    always_comb
    begin
        n              = cur;
        upd.pos_we     = 1'b0;
        upd.use_filter = 1'b0;
        gain_sel       = cfg.filter_gain;
        if (!cur.has_last)
        begin
            // first sample: store it as is
            n.has_last = 1'b1;
            upd.pos_we = 1'b1;
        end
        else if (!cur.active)
        begin
            if (moved)
            begin
                n.act_cnt = sat_inc(cur.act_cnt);
            end
            else if (cur.act_cnt != '0)
            begin
                n.act_cnt = cur.act_cnt - CNT_W'(1);
            end
            if (n.act_cnt > cfg.activation_amount)
            begin
                n.act_cnt = '0;
                n.active  = 1'b1;
            end
            upd.pos_we = 1'b1;
        end
        else
        begin
            n.gone_cnt = moved ? '0 : sat_inc(cur.gone_cnt);
            if (n.gone_cnt > cfg.disappeared_amount)
            begin
                n = '0;
            end
            if (small_move)
            begin
                n.still_cnt = sat_inc(n.still_cnt);
            end
            else
            begin
                n.still_cnt = '0;
                n.still     = 1'b0;
            end
            if (n.still_cnt > cfg.holds_still_amount)
            begin
                n.still = 1'b1;
            end
            n.noise_cnt = big_move ? sat_inc(n.noise_cnt) : '0;
            if (n.noise_cnt > cfg.noise_amount)
            begin
                n = '0;
            end
            gain_sel       = n.still ? cfg.still_filter_gain : cfg.filter_gain;
            upd.use_filter = 1'b1;
            // hold the stored position while a noise run is open
            if (n.noise_cnt == '0)
            begin
                upd.pos_we = 1'b1;
                n.has_last = 1'b1;
            end
        end
        upd.nxt  = n;
        upd.emit = n.active;
        upd.gain = gain_sel[GAIN_W-1] ? GAIN_ONE : gain_sel;
    end

endmodule

[src/marker_track_qualifier.sv]
// Channel  | Ports                      | Contents (lowest bit up)
// ---------+----------------------------+------------------------------------------
// sample   | s_tvalid s_tready s_tdata  | sensor_id[5], pos_x[32], pos_y[32], pos_z[32]
// result   | m_tvalid m_tready m_tdata  | out_sensor_id[5], out_x, out_y, out_z
//          | m_tuser                    | holding_still
// config   | cfg_we cfg_index cfg_data  | register index 0..7, data up to 20 bits
//
// A request is taken only while the read stage is empty, set by the read-modify-write of the
// per-sensor control and position RAMs: the read stage reads them and forms the differences,
// the update stage updates counters, filter and writes back. A result is loaded into the output
// register as its update stage drains. Reset loads the configuration defaults, clears a valid bit per
// control entry and the pipeline; the RAMs need no clearing pass. A stalled result holds
// the update stage, and no request is taken while that stage cannot drain.
module marker_track_qualifier
    import mtq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // sensor_id, pos_x, pos_y, pos_z, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // out_sensor_id, out_x, out_y, out_z, zero pad
    output logic [0:0]            m_tuser,   // holding_still
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    // Request fields
    logic [SID_W-1:0]  in_id;
    pos_t              in_pos;
    logic              in_ok;
    logic              accept;

    // Read stage
    logic              s1_valid_reg;
    logic [SID_W-1:0]  s1_id_reg;
    pos_t              s1_pos_reg;
    logic              s1_cvld_reg;

    // Update stage
    logic                     s2_valid_reg;
    logic                     s2_valid_next;
    logic [SID_W-1:0]         s2_id_reg;
    pos_t                     s2_pos_reg;
    logic signed [DIFF_W-1:0] s2_dx_reg;
    logic signed [DIFF_W-1:0] s2_dy_reg;
    logic signed [DIFF_W-1:0] s2_dz_reg;
    logic signed [DSUM_W-1:0] s2_dsum_reg;
    ctrl_t                    s2_ctrl_reg;
    logic                     s2_adv;

    // Last write to each RAM, forwarded to a read that raced it
    logic              bc_valid_reg;
    logic [SID_W-1:0]  bc_id_reg;
    ctrl_t             bc_ctrl_reg;
    logic              bp_valid_reg;
    logic [SID_W-1:0]  bp_id_reg;
    pos_t              bp_pos_reg;

    logic [MEM_DEPTH-1:0] cvld_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SID_W-1:0]  out_id_reg;
    pos_t              out_pos_reg;
    logic              out_still_reg;
    logic              out_free;

    logic [$bits(ctrl_t)-1:0] ctrl_rdata;
    logic [$bits(pos_t)-1:0]  pos_rdata;
    ctrl_t             ctrl_cur;
    pos_t              pos_cur;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic signed [DSUM_W-1:0] dsum;

    upd_t              upd;
    pos_t              filt_pos;
    pos_t              new_pos;
    logic              ctrl_we;
    logic              pos_we;

    // p + floor(g * d / 256) as one multiply-accumulate: (p * 256 + g * d) >> 8
    function automatic logic signed [POS_W-1:0] lowpass(
        input logic signed [POS_W-1:0]  p,
        input logic signed [DIFF_W-1:0] d,
        input logic [GAIN_W-1:0]        g
    );
        logic signed [ACC_W-1:0] acc;
        acc = $signed({{(ACC_W - POS_W - FRAC_W){p[POS_W-1]}}, p, {FRAC_W{1'b0}}})
            + ($signed({1'b0, g}) * d);
        lowpass = acc[FRAC_W +: POS_W];
    endfunction

    mtq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Accept: issue the RAM reads. Take a request only when the read stage
    // is empty and the update stage is empty or drains at this edge, so every earlier
    // write has either landed or is caught by the forwarding registers.
    // ------------------------------------------------------------------
    assign in_id    = s_tdata[SID_W-1:0];
    assign in_pos   = pos_t'(s_tdata[SID_W +: 3 * POS_W]);
    assign in_ok    = (int'(in_id) < MAX_SENSORS);
    assign out_free = !out_valid_reg || m_tready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s_tready = !s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign accept   = s_tvalid && s_tready;

    assign ctrl_we  = s2_adv;
    assign pos_we   = s2_adv && upd.pos_we;

    mtq_ram #(
        .WIDTH  ($bits(ctrl_t)),
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl_ram (
        .clk   (clk),
        .we    (ctrl_we),
        .waddr (s2_id_reg[ADDR_W-1:0]),
        .wdata (upd.nxt),
        .re    (accept),
        .raddr (in_id[ADDR_W-1:0]),
        .rdata (ctrl_rdata)
    );

    mtq_ram #(
        .WIDTH  ($bits(pos_t)),
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (s2_id_reg[ADDR_W-1:0]),
        .wdata (new_pos),
        .re    (accept),
        .raddr (in_id[ADDR_W-1:0]),
        .rdata (pos_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cvld_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= accept && in_ok;
            if (ctrl_we)
            begin
                cvld_reg[s2_id_reg[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_id_reg   <= in_id;
            s1_pos_reg  <= in_pos;
            s1_cvld_reg <= cvld_reg[in_id[ADDR_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Read stage: pick the freshest state, form the component differences
    // and their sum. A never-written control entry reads as cleared.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (bc_valid_reg && (bc_id_reg == s1_id_reg))
        begin
            ctrl_cur = bc_ctrl_reg;
        end
        else if (s1_cvld_reg)
        begin
            ctrl_cur = ctrl_t'(ctrl_rdata);
        end
        else
        begin
            ctrl_cur = '0;
        end
        if (bp_valid_reg && (bp_id_reg == s1_id_reg))
        begin
            pos_cur = bp_pos_reg;
        end
        else
        begin
            pos_cur = pos_t'(pos_rdata);
        end
    end

    assign dx   = {pos_cur.x[POS_W-1], pos_cur.x} - {s1_pos_reg.x[POS_W-1], s1_pos_reg.x};
    assign dy   = {pos_cur.y[POS_W-1], pos_cur.y} - {s1_pos_reg.y[POS_W-1], s1_pos_reg.y};
    assign dz   = {pos_cur.z[POS_W-1], pos_cur.z} - {s1_pos_reg.z[POS_W-1], s1_pos_reg.z};
    assign dsum = {{(DSUM_W - DIFF_W){dx[DIFF_W-1]}}, dx}
                + {{(DSUM_W - DIFF_W){dy[DIFF_W-1]}}, dy}
                + {{(DSUM_W - DIFF_W){dz[DIFF_W-1]}}, dz};

    // The read stage never stalls: the update stage is free whenever it holds an item
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_valid_reg)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_id_reg   <= s1_id_reg;
            s2_pos_reg  <= s1_pos_reg;
            s2_dx_reg   <= dx;
            s2_dy_reg   <= dy;
            s2_dz_reg   <= dz;
            s2_dsum_reg <= dsum;
            s2_ctrl_reg <= ctrl_cur;
        end
    end

    // ------------------------------------------------------------------
    // Update stage: counters and flags, filter, write back, load result.
    // ------------------------------------------------------------------
    mtq_update u_update (
        .cur  (s2_ctrl_reg),
        .dsum (s2_dsum_reg),
        .cfg  (cfg),
        .upd  (upd)
    );

    assign filt_pos.x = lowpass(s2_pos_reg.x, s2_dx_reg, upd.gain);
    assign filt_pos.y = lowpass(s2_pos_reg.y, s2_dy_reg, upd.gain);
    assign filt_pos.z = lowpass(s2_pos_reg.z, s2_dz_reg, upd.gain);
    assign new_pos    = upd.use_filter ? filt_pos : s2_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_valid_reg <= 1'b0;
            bp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl_we)
            begin
                bc_valid_reg <= 1'b1;
            end
            if (pos_we)
            begin
                bp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_we)
        begin
            bc_id_reg   <= s2_id_reg;
            bc_ctrl_reg <= upd.nxt;
        end
        if (pos_we)
        begin
            bp_id_reg  <= s2_id_reg;
            bp_pos_reg <= new_pos;
        end
    end

    // Load a result for an active sensor; drop the register once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_adv && upd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && upd.emit)
        begin
            out_id_reg    <= s2_id_reg;
            out_pos_reg   <= new_pos;
            out_still_reg <= upd.nxt.still;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{PAD_W{1'b0}}, out_pos_reg, out_id_reg};
    assign m_tuser[0] = out_still_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_read_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("read stage item did not reach the update stage");

    a_write_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_we |=> !ctrl_we)
        else $error("control RAM written in two consecutive cycles");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |-> !s_tready)
        else $error("request taken while update stage is held");

    a_pos_write_has_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        pos_we |-> (ctrl_we && upd.nxt.has_last))
        else $error("position written without a matching control update");

endmodule
